// File: sv/clsl_pkg.sv
// ----------------------------------------------------------------------------
// clsl_pkg: shared types, constants and byte classification
// Lexer modes, token roles, result record and the per-byte classify function.
// ----------------------------------------------------------------------------
package clsl_pkg;

  localparam int MAX_SOURCE_BYTES = 131072;
  localparam int OFF_W  = 17;
  localparam int LINE_W = 18;
  localparam int CNT_W  = 18;
  localparam logic [LINE_W-1:0] LINE_CAP = LINE_W'(131072);
  localparam logic [CNT_W-1:0]  SRC_CAP  = CNT_W'(MAX_SOURCE_BYTES);
  localparam logic [CNT_W-1:0]  SRC_LAST = CNT_W'(MAX_SOURCE_BYTES - 1);

  // result queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // characters of interest
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // token roles
  localparam logic [3:0] ROLE_SKIP        = 4'd0;
  localparam logic [3:0] ROLE_IDENT_START = 4'd1;
  localparam logic [3:0] ROLE_IDENT_CONT  = 4'd2;
  localparam logic [3:0] ROLE_INT_START   = 4'd3;
  localparam logic [3:0] ROLE_INT_CONT    = 4'd4;
  localparam logic [3:0] ROLE_OPEN_QUOTE  = 4'd5;
  localparam logic [3:0] ROLE_STR_CHAR    = 4'd6;
  localparam logic [3:0] ROLE_ESCAPE      = 4'd7;
  localparam logic [3:0] ROLE_CLOSE_QUOTE = 4'd8;
  localparam logic [3:0] ROLE_MARK        = 4'd9;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OPEN_CMT = 2'd1;
  localparam logic [1:0] ST_OPEN_STR = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef enum logic [3:0] {
    M_IDLE      = 4'd0,
    M_IDENT     = 4'd1,
    M_INT       = 4'd2,
    M_STR       = 4'd3,
    M_STR_ESC   = 4'd4,
    M_LINE      = 4'd5,
    M_BLK_OPEN  = 4'd6,
    M_BLK       = 4'd7,
    M_BLK_CLOSE = 4'd8
  } mode_t;

  typedef struct packed {
    logic [OFF_W-1:0]  byte_offset;
    logic [3:0]        role;
    logic [7:0]        text_byte;
    logic [LINE_W-1:0] token_line;
    logic [1:0]        status;
    logic              last_result;
  } res_t;

  // results handed from the lexer to the queue
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  // classification of one byte plus the lexer state it leaves
  typedef struct packed {
    logic [3:0]        role;
    logic [7:0]        text_byte;
    logic [LINE_W-1:0] token_line;
    mode_t             mode;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] start;
  } cls_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return l >= 8'h61 && l <= 8'h7a;
  endfunction

  function automatic logic is_ident_start(logic [7:0] c);
    return is_alpha(c) || (c == CH_USCORE);
  endfunction

  function automatic logic is_ident_part(logic [7:0] c);
    return is_ident_start(c) || is_digit(c);
  endfunction

  function automatic logic [LINE_W-1:0] bump(logic [LINE_W-1:0] l);
    return (l < LINE_CAP) ? l + LINE_W'(1) : l;
  endfunction

  function automatic cls_t classify(mode_t m, logic [7:0] c, logic has_next,
                                    logic [7:0] nxt, logic [LINE_W-1:0] line,
                                    logic [LINE_W-1:0] start);
    cls_t r;
    logic idle;
    r.role       = ROLE_SKIP;
    r.text_byte  = 8'd0;
    r.token_line = line;
    r.mode       = m;
    r.line       = line;
    r.start      = start;
    idle         = 1'b0;
    case (m)
      M_IDENT: begin
        if (is_ident_part(c)) begin
          r.role = ROLE_IDENT_CONT; r.text_byte = c; r.token_line = start;
        end else begin
          r.mode = M_IDLE; idle = 1'b1;
        end
      end
      M_INT: begin
        if (is_digit(c)) begin
          r.role = ROLE_INT_CONT; r.text_byte = c; r.token_line = start;
        end else begin
          r.mode = M_IDLE; idle = 1'b1;
        end
      end
      M_STR: begin
        r.token_line = start;
        if (c == CH_QUOTE) begin
          r.role = ROLE_CLOSE_QUOTE; r.mode = M_IDLE;
        end else if (c == CH_BSLASH && has_next) begin
          r.role = ROLE_ESCAPE; r.mode = M_STR_ESC;
        end else begin
          r.role = ROLE_STR_CHAR; r.text_byte = c;
          if (c == CH_NL) r.line = bump(line);
        end
      end
      M_STR_ESC: begin
        r.token_line = start;
        r.role = ROLE_STR_CHAR; r.text_byte = c; r.mode = M_STR;
      end
      M_LINE: begin
        if (c == CH_NL) begin
          r.mode = M_IDLE; idle = 1'b1;
        end
      end
      M_BLK_OPEN: r.mode = M_BLK;
      M_BLK: begin
        if (c == CH_NL) r.line = bump(line);
        if (c == CH_STAR && has_next && nxt == CH_SLASH) r.mode = M_BLK_CLOSE;
      end
      M_BLK_CLOSE: r.mode = M_IDLE;
      default: begin
        r.mode = M_IDLE; idle = 1'b1;
      end
    endcase
    // between tokens
    if (idle) begin
      if (is_space(c)) begin
        if (c == CH_NL) r.line = bump(r.line);
      end else if (c == CH_SLASH && has_next && nxt == CH_SLASH) begin
        r.mode = M_LINE;
      end else if (c == CH_SLASH && has_next && nxt == CH_STAR) begin
        r.mode = M_BLK_OPEN;
      end else begin
        r.start      = r.line;
        r.token_line = r.line;
        if (is_ident_start(c)) begin
          r.role = ROLE_IDENT_START; r.text_byte = c; r.mode = M_IDENT;
        end else if (is_digit(c)) begin
          r.role = ROLE_INT_START; r.text_byte = c; r.mode = M_INT;
        end else if (c == CH_QUOTE) begin
          r.role = ROLE_OPEN_QUOTE; r.mode = M_STR;
        end else begin
          r.role = ROLE_MARK; r.text_byte = c;
        end
      end
    end
    return r;
  endfunction

endpackage

// File: sv/c_like_script_lexer.sv
// ----------------------------------------------------------------------------
// c_like_script_lexer: streaming lexer for a small C-like script language
// Labels each source byte with its role in the token stream, one result per
// byte, delayed by one byte of lookahead.
// ----------------------------------------------------------------------------
// Path: a byte's result is pushed once the next byte's transaction leaves the
//   input register, then passes the result queue; the final transaction gives two results.
// Throughput: one byte per cycle while the queue has room; the queue drains one
//   result per cycle while m_tready is high, so a final byte's two results leave in turn.
// Reset: rst clears lexer state and queue; no clearing pass is needed.
module c_like_script_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] source_byte
  input  logic        s_tlast,   // end_of_source
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [16:0] byte_offset, [20:17] role,
                                 // [28:21] text_byte, [46:29] token_line,
                                 // [48:47] status, [55:49] zero
  output logic        m_tlast    // last_result
);
  import clsl_pkg::*;

  push_t push;
  logic  room;
  res_t  res;

  // byte classification and lexer state
  clsl_lex u_lex (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_end   (s_tlast),
    .room     (room),
    .push     (push)
  );

  // result queue
  clsl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // output packing
  assign m_tdata = {7'd0, res.status, res.token_line, res.text_byte, res.role,
                    res.byte_offset};
  assign m_tlast = res.last_result;

endmodule

// File: sv/clsl_lex.sv
// ----------------------------------------------------------------------------
// clsl_lex: input register and lexer state
// Holds one byte of lookahead, classifies bytes and hands up to two results
// per transaction to the result queue.
// ----------------------------------------------------------------------------
module clsl_lex (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_end,
  input  logic                room,
  output clsl_pkg::push_t     push
);
  import clsl_pkg::*;

  // input register
  logic       iv;
  logic [7:0] ib;
  logic       il;
  logic       adv;

  // lexer state
  mode_t             mode, mode_next;
  logic [7:0]        held_byte, held_byte_next;
  logic              held_valid, held_valid_next;
  logic [CNT_W-1:0]  byte_cnt, byte_cnt_next;
  logic [LINE_W-1:0] line_cnt, line_cnt_next;
  logic [LINE_W-1:0] start_line, start_line_next;

  cls_t              c1, c2;
  mode_t             mode_a;
  logic [LINE_W-1:0] line_a, start_a;
  logic [CNT_W-1:0]  held_off, cur_off, cnt_inc;
  logic [1:0]        status;
  res_t              res1, res2;

  assign adv      = iv && room;
  assign in_ready = !iv || adv;

  // input register load
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (in_valid && in_ready) begin
      iv <= 1'b1;
    end else if (adv) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ib <= in_byte;
      il <= in_end;
    end
  end

  // classify held byte with lookahead, then the current byte if it is final
  always_comb begin
    c1      = classify(mode, held_byte, 1'b1, ib, line_cnt, start_line);
    mode_a  = held_valid ? c1.mode : mode;
    line_a  = held_valid ? c1.line : line_cnt;
    start_a = held_valid ? c1.start : start_line;
    c2      = classify(mode_a, ib, 1'b0, 8'd0, line_a, start_a);

    held_off = byte_cnt - CNT_W'(1);
    if (held_off > SRC_LAST) held_off = SRC_LAST;
    cur_off = (byte_cnt < SRC_LAST) ? byte_cnt : SRC_LAST;
    cnt_inc = (byte_cnt <= SRC_CAP) ? byte_cnt + CNT_W'(1) : byte_cnt;

    if (cnt_inc > SRC_CAP) begin
      status = ST_TOO_LONG;
    end else if (c2.mode inside {M_BLK_OPEN, M_BLK, M_BLK_CLOSE}) begin
      status = ST_OPEN_CMT;
    end else if (c2.mode inside {M_STR, M_STR_ESC}) begin
      status = ST_OPEN_STR;
    end else begin
      status = ST_OK;
    end

    res1.byte_offset = held_off[OFF_W-1:0];
    res1.role        = c1.role;
    res1.text_byte   = c1.text_byte;
    res1.token_line  = c1.token_line;
    res1.status      = ST_OK;
    res1.last_result = 1'b0;

    res2.byte_offset = cur_off[OFF_W-1:0];
    res2.role        = c2.role;
    res2.text_byte   = c2.text_byte;
    res2.token_line  = c2.token_line;
    res2.status      = status;
    res2.last_result = 1'b1;

    push.n  = adv ? ({1'b0, held_valid} + {1'b0, il}) : 2'd0;
    push.r0 = held_valid ? res1 : res2;
    push.r1 = res2;
  end

  // state update
  always_comb begin
    mode_next       = mode;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    byte_cnt_next   = byte_cnt;
    line_cnt_next   = line_cnt;
    start_line_next = start_line;
    if (adv) begin
      if (il) begin
        mode_next       = M_IDLE;
        held_byte_next  = 8'd0;
        held_valid_next = 1'b0;
        byte_cnt_next   = '0;
        line_cnt_next   = LINE_W'(1);
        start_line_next = LINE_W'(1);
      end else begin
        mode_next       = mode_a;
        held_byte_next  = ib;
        held_valid_next = 1'b1;
        byte_cnt_next   = cnt_inc;
        line_cnt_next   = line_a;
        start_line_next = start_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      held_byte  <= 8'd0;
      held_valid <= 1'b0;
      byte_cnt   <= '0;
      line_cnt   <= LINE_W'(1);
      start_line <= LINE_W'(1);
    end else begin
      mode       <= mode_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      byte_cnt   <= byte_cnt_next;
      line_cnt   <= line_cnt_next;
      start_line <= start_line_next;
    end
  end

  // a final byte always leaves the lexer with nothing held
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (adv && il) |=> (!held_valid && byte_cnt == '0))
    else $error("lexer state not cleared after final byte");

  // a held byte means at least one byte was counted
  a_held_cnt: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> (byte_cnt != '0))
    else $error("held byte without byte count");

endmodule

// File: sv/clsl_outq.sv
// ----------------------------------------------------------------------------
// clsl_outq: result queue
// Four-entry queue taking up to two results per cycle while it has room and giving one while out_ready is high.
// ----------------------------------------------------------------------------
module clsl_outq (
  input  logic            clk,
  input  logic            rst,
  input  clsl_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output clsl_pkg::res_t  out_res
);
  import clsl_pkg::*;

  res_t              q [QDEPTH];
  logic [QPTR_W-1:0] wp, rp;
  logic [QCNT_W-1:0] cnt, cnt_next;
  logic              pop;
  logic [QPTR_W-1:0] wp1;

  assign room      = cnt <= QCNT_W'(QDEPTH - 2);
  assign out_valid = cnt != '0;
  assign out_res   = q[rp];
  assign pop       = out_valid && out_ready;
  assign wp1       = wp + QPTR_W'(1);
  assign cnt_next  = cnt + QCNT_W'(push.n) - QCNT_W'(pop);

  // entry writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q[wp] <= push.r0;
    if (push.n == 2'd2) q[wp1] <= push.r1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      wp  <= wp + QPTR_W'(push.n);
      rp  <= rp + QPTR_W'(pop);
      cnt <= cnt_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> room)
    else $error("result pushed without room");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wp - rp) == cnt[QPTR_W-1:0])
    else $error("queue pointers disagree with count");

endmodule
